// ===== hw/rtl/jmwc_pkg.sv =====
// Shared types, marker codes and phase codes of the JPEG marker walk carver.
// Depends on nothing; every module of the block imports it.
package jmwc_pkg;

    localparam int POS_BITS = 32;
    localparam int LEN_BITS = 32;
    localparam int SKIP_BITS = 17;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam logic [31:0] SCAN_LIMIT_RESET = 32'd52428800;

    // Parse phases.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SOI  = 3'd1;
    localparam logic [2:0] PH_HDR  = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_SCAN = 3'd4;

    // Outcome codes.
    localparam logic [1:0] OUT_FOUND   = 2'd0;
    localparam logic [1:0] OUT_BAD     = 2'd1;
    localparam logic [1:0] OUT_HDR_END = 2'd2;
    localparam logic [1:0] OUT_NO_END  = 2'd3;

    // Marker codes.
    localparam logic [15:0] MK_SOI  = 16'hffd8;
    localparam logic [15:0] MK_EOI  = 16'hffd9;
    localparam logic [15:0] MK_SOS  = 16'hffda;
    localparam logic [15:0] MK_COM  = 16'hfffe;
    localparam logic [15:0] MK_SOF0 = 16'hffc0;
    localparam logic [15:0] MK_DHT  = 16'hffc4;
    localparam logic [15:0] MK_SOF2 = 16'hffc2;
    localparam logic [15:0] MK_DQT  = 16'hffdb;
    localparam logic [15:0] MK_DRI  = 16'hffdd;
    localparam logic [15:0] MK_APP_MASK = 16'hfff0;
    localparam logic [15:0] MK_APP  = 16'hffe0;
    localparam logic [15:0] MK_RST_MASK = 16'hfff8;
    localparam logic [15:0] MK_RST  = 16'hffd0;
    localparam logic [7:0]  BYTE_FF = 8'hff;
    localparam logic [7:0]  BYTE_D9 = 8'hd9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       final_byte;
    } t_item;

    typedef struct packed {
        logic                valid;
        logic [1:0]          outcome;
        logic [LEN_BITS-1:0] image_length;
    } t_result;

    // Markers that carry a length field (DRI included, its length is fixed).
    function automatic logic is_len_marker(input logic [15:0] mk);
        return mk == MK_COM || mk == MK_SOF0 || mk == MK_DHT || mk == MK_SOF2 ||
               mk == MK_DQT || mk == MK_DRI || (mk & MK_APP_MASK) == MK_APP ||
               (mk & MK_RST_MASK) == MK_RST;
    endfunction

endpackage

// ===== hw/rtl/jmwc_in_stage.sv =====
// Input register of the JPEG marker walk carver: holds one accepted byte item.
// Depends on jmwc_pkg for the item type.
module jmwc_in_stage
    import jmwc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_go,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign o_ready = !r_valid || i_go;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_go) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/jmwc_parser.sv =====
// Parse state and single-step next-state logic of the JPEG marker walk carver.
// Depends on jmwc_pkg for marker codes, phase codes and the item/result types.
module jmwc_parser
    import jmwc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  t_item       i_item,
    input  logic [31:0] i_scan_limit,
    output t_result     o_result
);

    logic [2:0]           r_phase, n_phase;
    logic [POS_BITS-1:0]  r_pos, n_pos;
    logic [SKIP_BITS-1:0] r_skip, n_skip;
    logic [31:0]          r_hdr, n_hdr;
    logic [2:0]           r_cnt, n_cnt;
    logic                 r_ff, n_ff;

    always_comb begin
        logic [POS_BITS-1:0]  cur;
        logic [SKIP_BITS-1:0] seg;
        logic [POS_BITS:0]    len_ext;
        logic                 do_two;
        logic                 has;
        logic [1:0]           code;
        logic [15:0]          mk;

        n_phase = r_phase;
        n_pos   = r_pos;
        n_skip  = r_skip;
        n_hdr   = r_hdr;
        n_cnt   = r_cnt;
        n_ff    = r_ff;
        has     = 1'b0;
        code    = OUT_FOUND;
        len_ext = '0;
        do_two  = 1'b0;
        seg     = '0;
        mk      = '0;

        if (i_item.first_byte) begin
            n_phase = PH_SOI;
            n_pos   = '0;
            n_skip  = '0;
            n_hdr   = '0;
            n_cnt   = '0;
            n_ff    = 1'b0;
        end
        cur = n_pos;

        if (n_phase != PH_IDLE) begin
            n_pos = (cur != POS_MAX) ? cur + 1'b1 : cur;
            case (n_phase)
                PH_SOI: begin
                    n_hdr = {n_hdr[23:0], i_item.data_byte};
                    n_cnt = n_cnt + 3'd1;
                    if (n_cnt >= 3'd2) begin
                        if (n_hdr[15:0] == MK_SOI) begin
                            n_cnt   = '0;
                            n_phase = PH_HDR;
                        end else begin
                            has  = 1'b1;
                            code = OUT_BAD;
                        end
                    end
                end
                PH_HDR: begin
                    n_hdr = {n_hdr[23:0], i_item.data_byte};
                    n_cnt = n_cnt + 3'd1;
                    if (n_cnt == 3'd2) begin
                        do_two = 1'b1;
                    end else if (n_cnt >= 3'd4) begin
                        seg = (n_hdr[31:16] == MK_DRI) ? SKIP_BITS'(6)
                            : {1'b0, n_hdr[15:0]} + SKIP_BITS'(2);
                        if (seg >= SKIP_BITS'(4)) begin
                            n_cnt  = '0;
                            n_skip = seg - SKIP_BITS'(4);
                            if (n_skip != '0) begin
                                n_phase = PH_SKIP;
                            end
                        end else if (seg == SKIP_BITS'(2)) begin
                            // The length bytes are replayed as the next marker.
                            n_hdr  = {16'h0000, n_hdr[15:0]};
                            n_cnt  = 3'd2;
                            do_two = 1'b1;
                        end else begin
                            n_hdr = {24'h000000, n_hdr[7:0]};
                            n_cnt = 3'd1;
                        end
                    end
                end
                PH_SKIP: begin
                    if (n_skip != '0) begin
                        n_skip = n_skip - 1'b1;
                    end
                    if (n_skip == '0) begin
                        n_phase = PH_HDR;
                    end
                end
                PH_SCAN: begin
                    if (n_cnt != '0) begin
                        if (n_ff && i_item.data_byte == BYTE_D9 &&
                            (n_cnt == 3'd1 ||
                             (cur - 1'b1) < POS_BITS'(i_scan_limit))) begin
                            has     = 1'b1;
                            code    = OUT_FOUND;
                            len_ext = {1'b0, cur} + 1'b1;
                        end else if (cur >= POS_BITS'(i_scan_limit)) begin
                            has  = 1'b1;
                            code = OUT_NO_END;
                        end
                    end
                    if (n_cnt < 3'd2) begin
                        n_cnt = n_cnt + 3'd1;
                    end
                    n_ff = (i_item.data_byte == BYTE_FF);
                end
                default: begin
                end
            endcase

            if (do_two) begin
                mk = n_hdr[15:0];
                if (mk == MK_SOI || mk == MK_EOI) begin
                    n_cnt = '0;
                end else if (mk == MK_SOS) begin
                    n_cnt   = '0;
                    n_ff    = 1'b0;
                    n_phase = PH_SCAN;
                end else if (!is_len_marker(mk)) begin
                    has  = 1'b1;
                    code = OUT_BAD;
                end
            end

            if (!has && i_item.final_byte) begin
                has  = 1'b1;
                code = (n_phase == PH_SCAN) ? OUT_NO_END : OUT_HDR_END;
            end
            if (has) begin
                n_phase = PH_IDLE;
            end
        end

        o_result.valid   = has;
        o_result.outcome = code;
        if (code != OUT_FOUND) begin
            o_result.image_length = '0;
        end else if (len_ext[POS_BITS:LEN_BITS] != '0) begin
            o_result.image_length = {LEN_BITS{1'b1}};
        end else begin
            o_result.image_length = len_ext[LEN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_skip  <= '0;
            r_hdr   <= '0;
            r_cnt   <= '0;
            r_ff    <= 1'b0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_skip  <= n_skip;
            r_hdr   <= n_hdr;
            r_cnt   <= n_cnt;
            r_ff    <= n_ff;
        end
    end

endmodule

// ===== hw/rtl/jmwc_out_stage.sv =====
// Result register of the JPEG marker walk carver: holds one result until taken.
// Depends on jmwc_pkg for the result type.
module jmwc_out_stage
    import jmwc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_result             i_result,
    output logic                o_can_take,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [LEN_BITS-1:0] o_length,
    output logic [1:0]          o_outcome
);

    logic                r_valid;
    logic                n_valid;
    logic [LEN_BITS-1:0] r_length;
    logic [1:0]          r_outcome;

    assign o_can_take = !r_valid || i_ready;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_length  <= i_result.image_length;
            r_outcome <= i_result.outcome;
        end
    end

    assign o_valid   = r_valid;
    assign o_length  = r_length;
    assign o_outcome = r_outcome;

endmodule

// ===== hw/rtl/jpeg_marker_walk_carver.sv =====
// Top level of the JPEG marker walk carver: input register, parser, result register
// and the scan limit register. Depends on jmwc_pkg, jmwc_in_stage, jmwc_parser, jmwc_out_stage.
//
//   channel   direction  handshake                  payload
//   s         in         i_s_tvalid / o_s_tready    tdata data_byte, tuser first_byte,
//                                                   tlast final_byte
//   m         out        o_m_tvalid / i_m_tready    tdata image_length, tuser outcome
//   cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_data scan_limit
//
// One byte is accepted per cycle unless held; a result passes the input and result registers.
// The parser steps one byte per cycle from the input register into the result register.
// A full result register that is not taken holds the parser and then the input side.
// Reset is synchronous and active low; it returns the parser to idle and the limit to
// its default. The configuration channel is always ready.
module jpeg_marker_walk_carver
    import jmwc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] first_byte
    input  logic        i_s_tlast,   // final_byte

    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] image_length
    output logic [1:0]  o_m_tuser,   // [1:0] outcome

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic        cfg_write;
    logic [31:0] r_limit;
    t_item       s_item;
    t_item       p_item;
    logic        p_valid;
    logic        can_take;
    logic        go;
    t_result     result;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= SCAN_LIMIT_RESET;
        end else if (cfg_write) begin
            r_limit <= i_cfg_data;
        end
    end

    assign s_item.data_byte  = i_s_tdata;
    assign s_item.first_byte = i_s_tuser;
    assign s_item.final_byte = i_s_tlast;

    assign go = p_valid && can_take;

    jmwc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (s_item),
        .i_go    (go),
        .o_valid (p_valid),
        .o_item  (p_item)
    );

    jmwc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_item       (p_item),
        .i_scan_limit (r_limit),
        .o_result     (result)
    );

    jmwc_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (go && result.valid),
        .i_result   (result),
        .o_can_take (can_take),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_length   (o_m_tdata),
        .o_outcome  (o_m_tuser)
    );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the JPEG marker walk carver: candidate byte streams go in,
// and each result is checked against a local model of the marker walk and end-marker scan.
// Depends on jmwc_pkg and jpeg_marker_walk_carver.
module testbench;
    import jmwc_pkg::*;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [31:0] image_length;
    } t_verdict;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'h0;

    // Local copy of the parser state and of the scan limit.
    logic [2:0]  walk_phase = PH_IDLE;
    logic [31:0] walk_pos = '0;
    logic [16:0] skip_left = '0;
    logic [31:0] hdr_window = '0;
    logic [2:0]  hdr_count = '0;
    logic        prev_ff = 1'b0;
    logic [31:0] limit_now = SCAN_LIMIT_RESET;

    t_verdict    verdicts_due[$];
    logic [7:0]  image_bytes[$];
    int          mismatch_count = 0;
    int          parsed_bytes = 0;
    int          verdicts_issued = 0;
    int          feed_idle_pct = 0;
    int          sink_stall_pct = 0;

    jpeg_marker_walk_carver DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic takes_length(input logic [15:0] mk);
        return mk == MK_COM || mk == MK_SOF0 || mk == MK_SOF2 || mk == MK_DHT ||
               mk == MK_DQT || mk == MK_DRI || (mk & MK_APP_MASK) == MK_APP ||
               (mk & MK_RST_MASK) == MK_RST;
    endfunction

    // Looks at the two marker bytes held in the low half of the header window.
    task automatic judge_marker(output logic bad);
        logic [15:0] mk;
        mk = hdr_window[15:0];
        bad = 1'b0;
        if (mk == MK_SOI || mk == MK_EOI) begin
            hdr_count = 3'd0;
        end else if (mk == MK_SOS) begin
            hdr_count = 3'd0;
            prev_ff = 1'b0;
            walk_phase = PH_SCAN;
        end else if (!takes_length(mk)) begin
            bad = 1'b1;
        end
    endtask

    task automatic carve_predict(input logic [7:0] b, input logic fb, input logic lb);
        logic [31:0] at;
        logic [32:0] found_len;
        logic [16:0] seg_len;
        logic [1:0]  code;
        logic        done;
        logic        bad;
        logic [2:0]  seen;
        t_verdict    v;
        done = 1'b0;
        bad = 1'b0;
        code = OUT_FOUND;
        found_len = '0;
        if (fb) begin
            walk_phase = PH_SOI;
            walk_pos = '0;
            skip_left = '0;
            hdr_window = '0;
            hdr_count = '0;
            prev_ff = 1'b0;
        end
        if (walk_phase == PH_IDLE)
            return;
        parsed_bytes++;
        at = walk_pos;
        if (walk_pos != POS_MAX)
            walk_pos = walk_pos + 32'd1;
        case (walk_phase)
            PH_SOI: begin
                hdr_window = {hdr_window[23:0], b};
                hdr_count++;
                if (hdr_count >= 3'd2) begin
                    if (hdr_window[15:0] == MK_SOI) begin
                        hdr_count = 3'd0;
                        walk_phase = PH_HDR;
                    end else begin
                        done = 1'b1;
                        code = OUT_BAD;
                    end
                end
            end
            PH_HDR: begin
                hdr_window = {hdr_window[23:0], b};
                hdr_count++;
                if (hdr_count == 3'd2) begin
                    judge_marker(bad);
                end else if (hdr_count >= 3'd4) begin
                    seg_len = (hdr_window[31:16] == MK_DRI) ? 17'd6
                                                            : {1'b0, hdr_window[15:0]} + 17'd2;
                    if (seg_len >= 17'd4) begin
                        hdr_count = 3'd0;
                        skip_left = seg_len - 17'd4;
                        if (skip_left != 0)
                            walk_phase = PH_SKIP;
                    end else if (seg_len == 17'd2) begin
                        // The next marker starts at the length field just taken in.
                        hdr_window = {16'h0, hdr_window[15:0]};
                        hdr_count = 3'd2;
                        judge_marker(bad);
                    end else begin
                        hdr_window = {24'h0, hdr_window[7:0]};
                        hdr_count = 3'd1;
                    end
                end
                if (bad) begin
                    done = 1'b1;
                    code = OUT_BAD;
                end
            end
            PH_SKIP: begin
                if (skip_left != 0)
                    skip_left--;
                if (skip_left == 0)
                    walk_phase = PH_HDR;
            end
            PH_SCAN: begin
                seen = hdr_count;
                if (seen >= 3'd1) begin
                    if (prev_ff && b == BYTE_D9 && (seen == 3'd1 || at - 32'd1 < limit_now)) begin
                        done = 1'b1;
                        code = OUT_FOUND;
                        found_len = {1'b0, at} + 33'd1;
                    end else if (at >= limit_now) begin
                        done = 1'b1;
                        code = OUT_NO_END;
                    end
                end
                if (seen < 3'd2)
                    hdr_count = seen + 3'd1;
                prev_ff = (b == BYTE_FF);
            end
            default: ;
        endcase
        if (!done && lb) begin
            done = 1'b1;
            code = (walk_phase == PH_SCAN) ? OUT_NO_END : OUT_HDR_END;
        end
        if (done) begin
            walk_phase = PH_IDLE;
            v.outcome = code;
            if (code != OUT_FOUND)
                v.image_length = '0;
            else
                v.image_length = found_len[32] ? 32'hffff_ffff : found_len[31:0];
            verdicts_due.push_back(v);
            verdicts_issued++;
        end
    endtask

    // Each transfer on the result side is compared with the oldest prediction.
    always @(posedge clk) begin : check_results
        t_verdict want;
        if (rst_n && m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: result with none expected, outcome %0d length %0d",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = verdicts_due.pop_front();
                if (m_tuser != want.outcome) begin
                    $display("%0t: outcome expected %0d actual %0d",
                             $time, want.outcome, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata != want.image_length) begin
                    $display("%0t: image_length expected %0d actual %0d",
                             $time, want.image_length, m_tdata);
                    mismatch_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic fb, input logic lb);
        if ($urandom_range(99, 0) < feed_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= fb;
        s_tlast <= lb;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        carve_predict(b, fb, lb);
    endtask

    // A final_at outside the candidate leaves it open for the next first byte.
    task automatic send_candidate(input int final_at);
        int k;
        for (k = 0; k < image_bytes.size(); k++)
            send_byte(image_bytes[k], k == 0, k == final_at);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_scan_limit(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        limit_now = value;
    endtask

    task automatic push_word(input logic [15:0] w);
        image_bytes.push_back(w[15:8]);
        image_bytes.push_back(w[7:0]);
    endtask

    // An image with random segments, payloads and scan data, well formed but for an occasional short COM length.
    task automatic compose_image();
        int          nseg;
        int          kind;
        int          n;
        logic [15:0] mk;
        image_bytes.delete();
        push_word(MK_SOI);
        nseg = $urandom_range(4, 0);
        repeat (nseg) begin
            kind = $urandom_range(8, 0);
            case (kind)
                0: mk = MK_COM;
                1: mk = MK_SOF0;
                2: mk = MK_SOF2;
                3: mk = MK_DHT;
                4: mk = MK_DQT;
                5: mk = MK_APP | 16'($urandom_range(15, 0));
                6: mk = MK_RST | 16'($urandom_range(7, 0));
                7: mk = MK_DRI;
                default: mk = $urandom_range(1, 0) ? MK_SOI : MK_EOI;
            endcase
            push_word(mk);
            if (mk == MK_DRI) begin
                // The length field of a restart interval is ignored.
                repeat (4) image_bytes.push_back(8'($urandom));
            end else if (takes_length(mk)) begin
                n = ($urandom_range(19, 0) == 0) ? $urandom_range(300, 40)
                                                 : $urandom_range(9, 0);
                push_word(16'(n + 2));
                repeat (n) image_bytes.push_back(8'($urandom));
            end
        end
        if ($urandom_range(11, 0) == 0) begin
            push_word(MK_COM);
            push_word(16'($urandom_range(1, 0)));
        end
        push_word(MK_SOS);
        n = $urandom_range(24, 0);
        repeat (n) image_bytes.push_back(($urandom_range(3, 0) == 0) ? BYTE_FF : 8'($urandom));
        push_word(MK_EOI);
        n = $urandom_range(3, 0);
        repeat (n) image_bytes.push_back(8'($urandom));
    endtask

    task automatic run_random_walk(input int byte_budget, input int verdict_floor);
        int stop_bytes;
        int stop_verdicts;
        int mode;
        int n;
        stop_bytes = parsed_bytes + byte_budget;
        stop_verdicts = verdicts_issued + verdict_floor;
        while (parsed_bytes < stop_bytes || verdicts_issued < stop_verdicts) begin
            mode = $urandom_range(19, 0);
            if (mode < 14) begin
                compose_image();
                send_candidate(image_bytes.size() - 1);
            end else if (mode < 16) begin
                compose_image();
                send_candidate($urandom_range(image_bytes.size() - 1, 0));
            end else if (mode < 18) begin
                compose_image();
                image_bytes[$urandom_range(image_bytes.size() - 1, 0)] = 8'($urandom);
                send_candidate(image_bytes.size() - 1);
            end else begin
                image_bytes.delete();
                n = $urandom_range(12, 1);
                if ($urandom_range(1, 0) == 1)
                    push_word(MK_SOI);
                repeat (n) image_bytes.push_back(8'($urandom));
                send_candidate($urandom_range(1, 0) ? image_bytes.size() - 1 : -1);
            end
        end
        // A short bad candidate leaves the parser idle before any register write.
        image_bytes.delete();
        push_word(MK_EOI);
        send_candidate(1);
    endtask

    task automatic test_directed();
        feed_idle_pct = 30;
        sink_stall_pct = 50;
        // A stray byte before any candidate is dropped.
        send_byte(BYTE_FF, 1'b0, 1'b0);
        image_bytes.delete();
        push_word(MK_EOI);
        send_candidate(1);
        image_bytes.delete();
        push_word(MK_SOI);
        push_word(MK_SOS);
        push_word(MK_EOI);
        send_candidate(5);
        image_bytes.delete();
        push_word(MK_SOI);
        image_bytes.push_back(BYTE_FF);
        image_bytes.push_back(8'h01);
        send_candidate(3);
        // Length field of one: the next marker starts on its low byte.
        image_bytes.delete();
        push_word(MK_SOI);
        push_word(MK_COM);
        push_word(16'h0001);
        image_bytes.push_back(8'h55);
        send_candidate(6);
        // Length field of zero: the field itself is taken as the next marker.
        image_bytes.delete();
        push_word(MK_SOI);
        push_word(MK_COM);
        push_word(16'h0000);
        send_candidate(5);
        image_bytes.delete();
        push_word(MK_SOI);
        image_bytes.push_back(BYTE_FF);
        send_candidate(2);
        image_bytes.delete();
        push_word(MK_SOI);
        push_word(MK_SOS);
        send_candidate(3);
        drain_results();
    endtask

    task automatic test_low_limit();
        write_scan_limit(32'd4);
        image_bytes.delete();
        push_word(MK_SOI);
        push_word(MK_SOS);
        push_word(16'h0000);
        push_word(MK_EOI);
        send_candidate(7);
        run_random_walk(350, 18);
        drain_results();
    endtask

    task automatic test_tight_limits();
        feed_idle_pct = 50;
        sink_stall_pct = 30;
        repeat (3) begin
            write_scan_limit(32'($urandom_range(80, 5)));
            run_random_walk(150, 8);
            drain_results();
        end
    endtask

    task automatic test_wide_limits();
        feed_idle_pct = 0;
        sink_stall_pct = 0;
        write_scan_limit(32'hffff_ffff);
        run_random_walk(300, 12);
        drain_results();
        write_scan_limit(SCAN_LIMIT_RESET);
        run_random_walk(300, 12);
    endtask

    initial begin
        int wait_cycles;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_low_limit();
        test_tight_limits();
        test_wide_limits();
        s_tvalid <= 1'b0;
        for (wait_cycles = 0; verdicts_due.size() != 0 && wait_cycles < 5000; wait_cycles++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (verdicts_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, verdicts_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
